// ===== hw/rtl/bdpc_pkg.sv =====
package bdpc_pkg;

    // Width of the debounce countdown and the hold counter
    localparam int CNT_W = 16;
    // Width of the configuration registers and of the write port
    localparam int CFG_W = 16;
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Register reset values
    localparam logic [CFG_W-1:0] DEBOUNCE_RST = CFG_W'(20);
    localparam logic [CFG_W-1:0] LONG_RST     = CFG_W'(1000);

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_DEBOUNCE = 1'b0,
        CFG_LONG     = 1'b1
    } t_cfg_idx;

    // Request codes of one input transaction
    typedef enum logic [1:0] {
        REQ_TICK       = 2'd0,
        REQ_READ_SHORT = 2'd1,
        REQ_READ_LONG  = 2'd2,
        REQ_CLEAR      = 2'd3
    } t_req;

    typedef struct packed {
        logic short_press;
        logic long_press;
        logic button_pressed;
    } t_result;

    // Debounce reload, saturated to the counter width
    function automatic logic [CNT_W-1:0] reload_of(input logic [CFG_W-1:0] ticks);
        logic [CMP_W-1:0] wide;
        wide = CMP_W'(ticks);
        if (wide > CMP_W'(CNT_MAX)) begin
            return CNT_MAX;
        end
        return CNT_W'(wide);
    endfunction

endpackage

// ===== hw/rtl/button_debounce_press_classifier.sv =====
// Button debouncer with short and long press classification.
//
// Input channel (i_in_valid / o_in_stall) carries one request per transaction:
// a tick with the raw pin level (0 = button down), a read of the short-press
// flag, a read of the long-press flag, or a clear of both flags.
// Output channel (o_out_valid / i_out_stall) returns exactly one result per
// request: the flag a read returned (else 0) and the debounced pressed state.
// The result is registered: it is in the output register at the edge after
// acceptance. Throughput is one transaction per cycle while no result stalls;
// the state update is one counter step and compare between the state registers.
// The configuration port writes debounce_ticks (index 0) and
// long_press_ticks (index 1) on any edge with i_cfg_we high; write only while
// no transaction is in flight.
// Reset (synchronous, active low) sets the registers to 20 and 1000, clears all
// flags and the hold count, reloads the countdown, and clears o_out_valid.
// While the receiver stalls a held result, o_in_stall rises and the result
// stays unchanged; a new request is taken in the cycle the result leaves.
module button_debounce_press_classifier (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [1:0]                 i_req_type,
    input  logic                       i_pin_level,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic                       o_short_press,
    output logic                       o_long_press,
    output logic                       o_button_pressed,
    input  logic                       i_cfg_we,
    input  logic [0:0]                 i_cfg_idx,
    input  logic [bdpc_pkg::CFG_W-1:0] i_cfg_data
);
    import bdpc_pkg::*;

    logic [CFG_W-1:0] r_debounce;
    logic [CFG_W-1:0] r_long_ticks;
    logic             r_out_valid;
    t_result          r_result;
    t_result          core_result;
    logic             in_accept;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_accept  = i_in_valid & ~o_in_stall;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce   <= DEBOUNCE_RST;
            r_long_ticks <= LONG_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_DEBOUNCE: r_debounce   <= i_cfg_data;
                CFG_LONG:     r_long_ticks <= i_cfg_data;
                default:      r_debounce   <= r_debounce;
            endcase
        end
    end

    bdpc_core u_core (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_en               (in_accept),
        .i_req              (t_req'(i_req_type)),
        .i_pin_level        (i_pin_level),
        .i_debounce_ticks   (r_debounce),
        .i_long_press_ticks (r_long_ticks),
        .o_result           (core_result)
    );

    // Hold the result until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_result <= core_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_short_press    = r_result.short_press;
    assign o_long_press     = r_result.long_press;
    assign o_button_pressed = r_result.button_pressed;

endmodule

// ===== hw/rtl/bdpc_core.sv =====
module bdpc_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  bdpc_pkg::t_req            i_req,
    input  logic                      i_pin_level,
    input  logic [bdpc_pkg::CFG_W-1:0] i_debounce_ticks,
    input  logic [bdpc_pkg::CFG_W-1:0] i_long_press_ticks,
    output bdpc_pkg::t_result         o_result
);
    import bdpc_pkg::*;

    logic             r_last_raw,  n_last_raw;
    logic [CNT_W-1:0] r_countdown, n_countdown;
    logic             r_deb,       n_deb;
    logic [CNT_W-1:0] r_held,      n_held;
    logic             r_long_read, n_long_read;
    logic             r_short,     n_short;
    logic             r_long,      n_long;

    logic             down;
    logic [CNT_W-1:0] held_inc;
    logic             held_is_long;
    logic             prev_is_long;

    assign down = ~i_pin_level;

    // Saturating hold count for a pressed tick
    assign held_inc = (r_held == CNT_MAX) ? r_held : r_held + CNT_W'(1);

    // Threshold compares on the hold count after and before this tick
    assign held_is_long = CMP_W'(held_inc) >= CMP_W'(i_long_press_ticks);
    assign prev_is_long = CMP_W'(r_held) >= CMP_W'(i_long_press_ticks);

    // Next state for one transaction. The level seen at the previous tick's
    // end always equals the current debounced state, so r_deb serves both.
    always_comb begin
        n_last_raw  = r_last_raw;
        n_countdown = r_countdown;
        n_deb       = r_deb;
        n_held      = r_held;
        n_long_read = r_long_read;
        n_short     = r_short;
        n_long      = r_long;
        o_result    = '0;
        case (i_req)
            REQ_TICK: begin
                if (down != r_last_raw) begin
                    n_countdown = reload_of(i_debounce_ticks);
                end else if (r_countdown != '0) begin
                    n_countdown = r_countdown - CNT_W'(1);
                end
                if (n_countdown == '0) begin
                    n_deb = down;
                end
                if (n_deb) begin
                    n_held = held_inc;
                    if (held_is_long && !r_long_read) begin
                        n_long = 1'b1;
                    end
                end else begin
                    if (r_deb && !prev_is_long) begin
                        n_short = 1'b1;
                    end
                    n_held      = '0;
                    n_long_read = 1'b0;
                end
                n_last_raw = down;
            end
            REQ_READ_SHORT: begin
                if (r_short) begin
                    n_short              = 1'b0;
                    o_result.short_press = 1'b1;
                end
            end
            REQ_READ_LONG: begin
                if (r_long) begin
                    n_long              = 1'b0;
                    n_long_read         = 1'b1;
                    o_result.long_press = 1'b1;
                end
            end
            REQ_CLEAR: begin
                n_short = 1'b0;
                n_long  = 1'b0;
            end
            default: begin
                n_short = r_short;
            end
        endcase
        o_result.button_pressed = n_deb;
    end

    // Advance state on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw  <= 1'b0;
            r_countdown <= reload_of(DEBOUNCE_RST);
            r_deb       <= 1'b0;
            r_held      <= '0;
            r_long_read <= 1'b0;
            r_short     <= 1'b0;
            r_long      <= 1'b0;
        end else if (i_en) begin
            r_last_raw  <= n_last_raw;
            r_countdown <= n_countdown;
            r_deb       <= n_deb;
            r_held      <= n_held;
            r_long_read <= n_long_read;
            r_short     <= n_short;
            r_long      <= n_long;
        end
    end

endmodule

// ===== hw/rtl/bdpc_checker.sv =====
module bdpc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input logic o_short_press,
    input logic o_long_press
);

    // Held result stays presented while the receiver stalls
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // Input is stalled only behind a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a stalled result");

    // Every accepted transaction shows a result on the next cycle
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_out_valid)
        else $error("accepted transaction gave no result");

    // A single request never returns both flags
    a_one_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_short_press && o_long_press))
        else $error("short and long press returned together");

endmodule

bind button_debounce_press_classifier bdpc_checker u_bdpc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_short_press (o_short_press),
    .o_long_press  (o_long_press)
);

// ===== tb/button_debounce_press_classifier_test.sv =====
`timescale 1ns / 100ps

module button_debounce_press_classifier_test;
    import bdpc_pkg::*;

    localparam int RUN_LIMIT      = 1_000_000;
    localparam int HOLDOFF_CYCLES = 200;
    localparam int SCRIPT_LEN     = 36;

    // Expected result words: {short_press, long_press, button_pressed}
    localparam t_result BTN_UP    = 3'b000;
    localparam t_result PRESSED   = 3'b001;
    localparam t_result SHORT_UP  = 3'b100;
    localparam t_result LONG_DOWN = 3'b011;
    localparam t_result LONG_UP   = 3'b010;

    // One line of the directed script: a register write or a transaction
    typedef struct {
        logic            is_cfg;
        t_cfg_idx        idx;
        logic [CFG_W-1:0] data;
        t_req            req;
        logic            pin;
        logic            typed;
        t_result         want;
    } t_script_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_stall;
    logic [1:0]       i_req_type = REQ_TICK;
    logic             i_pin_level = 1'b1;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    logic             o_short_press;
    logic             o_long_press;
    logic             o_button_pressed;
    logic             i_cfg_we = 1'b0;
    logic [0:0]       i_cfg_idx = CFG_DEBOUNCE;
    logic [CFG_W-1:0] i_cfg_data = '0;

    // Predicted block state and registers
    logic [CFG_W-1:0] cfg_settle = DEBOUNCE_RST;
    logic [CFG_W-1:0] cfg_long   = LONG_RST;
    logic             raw_down_q = 1'b0;
    logic [CNT_W-1:0] settle_cnt = CNT_W'(DEBOUNCE_RST);
    logic             deb_down   = 1'b0;
    logic             deb_down_q = 1'b0;
    logic [CNT_W-1:0] hold_cnt   = '0;
    logic             long_seen  = 1'b0;
    logic             short_pend = 1'b0;
    logic             long_pend  = 1'b0;

    t_result press_expect [$];

    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    int holdoff_asked = 0;
    int holdoff_taken = 0;
    int cycles = 0;
    int mismatches = 0;
    int items_sent = 0;
    int cfg_writes = 0;
    int short_reads = 0;
    int long_reads = 0;

    t_script_row script [SCRIPT_LEN] = '{
        // out of reset: defaults 20 / 1000, nothing pressed, flags clear
        '{1'b0, CFG_DEBOUNCE, 16'd0,     REQ_READ_SHORT, 1'b1, 1'b1, BTN_UP},
        '{1'b0, CFG_DEBOUNCE, 16'd0,     REQ_READ_LONG,  1'b0, 1'b1, BTN_UP},
        '{1'b0, CFG_DEBOUNCE, 16'd0,     REQ_CLEAR,      1'b1, 1'b1, BTN_UP},
        '{1'b0, CFG_DEBOUNCE, 16'd0,     REQ_TICK,       1'b1, 1'b1, BTN_UP},
        '{1'b0, CFG_DEBOUNCE, 16'd0,     REQ_TICK,       1'b0, 1'b1, BTN_UP},
        // zero debounce, long press after three held ticks
        '{1'b1, CFG_DEBOUNCE, 16'd0,     REQ_TICK,       1'b1, 1'b0, BTN_UP},
        '{1'b1, CFG_LONG,     16'd3,     REQ_TICK,       1'b1, 1'b0, BTN_UP},
        '{1'b0, CFG_DEBOUNCE, 16'd0,     REQ_TICK,       1'b1, 1'b1, BTN_UP},
        '{1'b0, CFG_DEBOUNCE, 16'd0,     REQ_TICK,       1'b0, 1'b1, PRESSED},
        '{1'b0, CFG_DEBOUNCE, 16'd0,     REQ_TICK,       1'b0, 1'b1, PRESSED},
        '{1'b0, CFG_DEBOUNCE, 16'd0,     REQ_TICK,       1'b0, 1'b1, PRESSED},
        '{1'b0, CFG_DEBOUNCE, 16'd0,     REQ_READ_LONG,  1'b1, 1'b1, LONG_DOWN},
        '{1'b0, CFG_DEBOUNCE, 16'd0,     REQ_READ_LONG,  1'b1, 1'b1, PRESSED},
        // long press already read: no new flag for the rest of this hold
        '{1'b0, CFG_DEBOUNCE, 16'd0,     REQ_TICK,       1'b0, 1'b1, PRESSED},
        '{1'b0, CFG_DEBOUNCE, 16'd0,     REQ_TICK,       1'b1, 1'b1, BTN_UP},
        // short tap
        '{1'b0, CFG_DEBOUNCE, 16'd0,     REQ_TICK,       1'b0, 1'b1, PRESSED},
        '{1'b0, CFG_DEBOUNCE, 16'd0,     REQ_TICK,       1'b1, 1'b1, BTN_UP},
        '{1'b0, CFG_DEBOUNCE, 16'd0,     REQ_READ_SHORT, 1'b0, 1'b1, SHORT_UP},
        '{1'b0, CFG_DEBOUNCE, 16'd0,     REQ_READ_SHORT, 1'b0, 1'b1, BTN_UP},
        // zero long threshold: any pressed tick is long, no release is short
        '{1'b1, CFG_LONG,     16'd0,     REQ_TICK,       1'b1, 1'b0, BTN_UP},
        '{1'b0, CFG_DEBOUNCE, 16'd0,     REQ_TICK,       1'b0, 1'b1, PRESSED},
        '{1'b0, CFG_DEBOUNCE, 16'd0,     REQ_TICK,       1'b1, 1'b1, BTN_UP},
        '{1'b0, CFG_DEBOUNCE, 16'd0,     REQ_READ_LONG,  1'b1, 1'b1, LONG_UP},
        // bounce around press and release with a two-tick debounce
        '{1'b1, CFG_LONG,     16'hFFFF,  REQ_TICK,       1'b1, 1'b0, BTN_UP},
        '{1'b1, CFG_DEBOUNCE, 16'd2,     REQ_TICK,       1'b1, 1'b0, BTN_UP},
        '{1'b0, CFG_DEBOUNCE, 16'd0,     REQ_TICK,       1'b0, 1'b0, BTN_UP},
        '{1'b0, CFG_DEBOUNCE, 16'd0,     REQ_TICK,       1'b0, 1'b0, BTN_UP},
        '{1'b0, CFG_DEBOUNCE, 16'd0,     REQ_TICK,       1'b0, 1'b0, BTN_UP},
        '{1'b0, CFG_DEBOUNCE, 16'd0,     REQ_TICK,       1'b1, 1'b0, BTN_UP},
        '{1'b0, CFG_DEBOUNCE, 16'd0,     REQ_CLEAR,      1'b0, 1'b0, BTN_UP},
        '{1'b0, CFG_DEBOUNCE, 16'd0,     REQ_TICK,       1'b0, 1'b0, BTN_UP},
        '{1'b0, CFG_DEBOUNCE, 16'd0,     REQ_TICK,       1'b1, 1'b0, BTN_UP},
        '{1'b0, CFG_DEBOUNCE, 16'd0,     REQ_TICK,       1'b1, 1'b0, BTN_UP},
        '{1'b0, CFG_DEBOUNCE, 16'd0,     REQ_TICK,       1'b1, 1'b0, BTN_UP},
        '{1'b0, CFG_DEBOUNCE, 16'd0,     REQ_CLEAR,      1'b1, 1'b0, BTN_UP},
        '{1'b0, CFG_DEBOUNCE, 16'd0,     REQ_READ_SHORT, 1'b1, 1'b1, BTN_UP}
    };

    button_debounce_press_classifier dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_req_type       (i_req_type),
        .i_pin_level      (i_pin_level),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_short_press    (o_short_press),
        .o_long_press     (o_long_press),
        .o_button_pressed (o_button_pressed),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > RUN_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r = $urandom_range(0, 19);
        if (r < 16) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Advance the predicted state by one transaction and return its result
    function automatic t_result debounce_step(input t_req req, input logic pin);
        t_result res;
        logic    down;
        res  = '0;
        down = ~pin;
        case (req)
            REQ_TICK: begin
                if (down != raw_down_q) begin
                    settle_cnt = (cfg_settle > CMP_W'(CNT_MAX)) ? CNT_MAX : CNT_W'(cfg_settle);
                end else if (settle_cnt != '0) begin
                    settle_cnt = settle_cnt - 1'b1;
                end
                if (settle_cnt == '0) begin
                    deb_down = down;
                end
                if (deb_down) begin
                    if (hold_cnt != CNT_MAX) begin
                        hold_cnt = hold_cnt + 1'b1;
                    end
                    if (hold_cnt >= cfg_long && !long_seen) begin
                        long_pend = 1'b1;
                    end
                end else begin
                    if (deb_down_q && hold_cnt < cfg_long) begin
                        short_pend = 1'b1;
                    end
                    hold_cnt  = '0;
                    long_seen = 1'b0;
                end
                raw_down_q = down;
                deb_down_q = deb_down;
            end
            REQ_READ_SHORT: begin
                res.short_press = short_pend;
                short_pend = 1'b0;
            end
            REQ_READ_LONG: begin
                if (long_pend) begin
                    res.long_press = 1'b1;
                    long_pend = 1'b0;
                    long_seen = 1'b1;
                end
            end
            default: begin
                short_pend = 1'b0;
                long_pend  = 1'b0;
            end
        endcase
        res.button_pressed = deb_down;
        return res;
    endfunction

    // Offer one transaction, hold it until taken, then queue its result
    task automatic send_item(input t_req req, input logic pin, input logic typed,
                             input t_result want);
        int      gap;
        logic    taken;
        t_result res;
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            gap = pick_gap();
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_req_type  <= req;
        i_pin_level <= pin;
        do begin
            @(negedge i_clk);
            taken = !o_in_stall;
            @(posedge i_clk);
        end while (!taken);
        res = debounce_step(req, pin);
        press_expect.push_back(typed ? want : res);
        items_sent++;
    endtask

    // Stop offering and wait until every result has left the block
    task automatic drain();
        i_in_valid <= 1'b0;
        while (press_expect.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_DEBOUNCE) begin
            cfg_settle = val;
        end else begin
            cfg_long = val;
        end
        cfg_writes++;
    endtask

    // Random phase: a button held and released for random spans, with contact
    // bounce after each edge, stray glitches, and flag reads and clears mixed in
    task automatic run_phase(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] lng,
                             input int count, input bit txi, input bit rxi,
                             input bit squeeze);
        int   span;
        int   run_left;
        int   since_edge;
        int   pick;
        logic level;
        logic pin;
        t_req req;
        drain();
        write_reg(CFG_DEBOUNCE, deb);
        write_reg(CFG_LONG, lng);
        tx_idle_on = txi;
        rx_idle_on = rxi;
        span = ((deb > 40) ? 40 : int'(deb)) + ((lng > 40) ? 40 : int'(lng)) + 4;
        level = 1'b1;
        run_left = 0;
        since_edge = 99;
        for (int k = 0; k < count; k++) begin
            if (squeeze && k == count / 4) begin
                holdoff_asked++;
            end
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                req = REQ_READ_SHORT;
            end else if (pick < 20) begin
                req = REQ_READ_LONG;
            end else if (pick < 24) begin
                req = REQ_CLEAR;
            end else begin
                req = REQ_TICK;
            end
            pin = 1'($urandom_range(0, 1));
            if (req == REQ_TICK) begin
                if (run_left == 0) begin
                    level = ~level;
                    run_left = $urandom_range(1, span);
                    since_edge = 0;
                end
                run_left--;
                pin = level;
                if (since_edge < 4 && $urandom_range(0, 3) == 0) begin
                    pin = ~level;
                end else if ($urandom_range(0, 49) == 0) begin
                    pin = ~level;
                end
                since_edge++;
            end
            send_item(req, pin, 1'b0, BTN_UP);
        end
    endtask

    // Receiver: random stalls, plus a long hold-off on request
    initial begin : receiver
        int g;
        forever begin
            @(posedge i_clk);
            if (holdoff_taken != holdoff_asked) begin
                holdoff_taken = holdoff_asked;
                i_out_stall <= 1'b1;
                repeat (HOLDOFF_CYCLES - 1) @(posedge i_clk);
            end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
                g = pick_gap();
                i_out_stall <= 1'b1;
                repeat (g - 1) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Check each result transaction against the oldest expectation
    always @(negedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_short_press, o_long_press, o_button_pressed};
            short_reads += int'(got.short_press);
            long_reads  += int'(got.long_press);
            if (press_expect.size() == 0) begin
                if (mismatches < 10) begin
                    $display("unexpected result short=%0b long=%0b pressed=%0b",
                             got.short_press, got.long_press, got.button_pressed);
                end
                mismatches++;
            end else begin
                want = press_expect.pop_front();
                if (got.short_press !== want.short_press ||
                    got.long_press !== want.long_press ||
                    got.button_pressed !== want.button_pressed) begin
                    if (mismatches < 10) begin
                        $display({"mismatch at cycle %0d: short %0b/%0b long %0b/%0b ",
                                  "pressed %0b/%0b (exp/got)"},
                                 cycles, want.short_press, got.short_press,
                                 want.long_press, got.long_press,
                                 want.button_pressed, got.button_pressed);
                    end
                    mismatches++;
                end
            end
        end
    end

    initial begin : stimulus
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed script
        foreach (script[r]) begin
            if (script[r].is_cfg) begin
                drain();
                write_reg(script[r].idx, script[r].data);
            end else begin
                send_item(script[r].req, script[r].pin, script[r].typed, script[r].want);
            end
        end

        // Random phases over several register settings
        run_phase(16'd0, 16'd1, 150, 1'b1, 1'b1, 1'b0);
        run_phase(16'd1, 16'd4, 150, 1'b0, 1'b0, 1'b0);
        run_phase(16'd3, 16'd12, 200, 1'b1, 1'b1, 1'b1);
        run_phase(CFG_W'($urandom_range(0, 5)), CFG_W'($urandom_range(1, 20)), 200,
                  1'b1, 1'b1, 1'b0);
        run_phase(16'hFFFF, 16'hFFFF, 50, 1'b1, 1'b1, 1'b0);
        run_phase(16'd2, 16'd8, 150, 1'b1, 1'b0, 1'b0);

        drain();
        repeat (4) @(posedge i_clk);
        $display("Covered %0d transactions under %0d register writes in %0d cycles.",
                 items_sent, cfg_writes, cycles);
        $display("Short presses read %0d, long presses read %0d, mismatches %0d.",
                 short_reads, long_reads, mismatches);
        if (mismatches == 0 && press_expect.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/bdpc_pkg.sv
hw/rtl/bdpc_core.sv
hw/rtl/button_debounce_press_classifier.sv
hw/rtl/bdpc_checker.sv
tb/button_debounce_press_classifier_test.sv
